// File: rtl/max_heap_delete_max_unit_assert.svh
// assertion macros for the heap delete-max unit
`ifndef MAX_HEAP_DELETE_MAX_UNIT_ASSERT_SVH
`define MAX_HEAP_DELETE_MAX_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define MHDM_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("heap unit check failed");
`define MHDM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("heap unit check failed");
`else
`define MHDM_ASSERT_NOW(label, clk, rst, ante, cons)
`define MHDM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: rtl/mhdm_pkg.sv
// shared constants for the heap delete-max unit
`default_nettype none
package mhdm_pkg;
   localparam int DATA_W   = 32;
   localparam int STATUS_W = 2;
   localparam int TOTAL_W  = 6;

   localparam logic OP_APPEND = 1'b0;
   localparam logic OP_DELETE = 1'b1;

   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

   typedef logic signed [DATA_W-1:0] word_type;
endpackage
`default_nettype wire

// File: rtl/max_heap_delete_max_unit.sv
// binary max-heap with append and delete-maximum, sift-down sequencer
//
// A command is taken when start is high and busy is low. req_opcode selects
// append (req_value is written at the end of the heap, no reordering) or
// delete of the root. Exactly one result word follows each command: rsp_valid
// is high for one cycle with rsp_removed_value, rsp_status and
// rsp_element_total. The receiver cannot stall; results are never held.
// Append, a delete on an empty heap and an append on a full heap answer in
// the next cycle and leave busy low, so these run one per cycle. A delete
// reads the root and then the last element, then walks down level by level
// (check, left child, right child) through the single ram read port and one
// shared signed comparator. busy stays high until the walk ends; the result
// word shows in the same cycle that busy falls, and the next command can be
// taken in that same cycle.
// Reset clears the element count; the heap ram is not cleared and needs no sweep.
`default_nettype none
`include "max_heap_delete_max_unit_assert.svh"
module max_heap_delete_max_unit #(
   parameter int CAPACITY = 32
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic                            req_opcode,
   input  wire logic signed [mhdm_pkg::DATA_W-1:0] req_value,
   output logic                                 rsp_valid,
   output logic signed [mhdm_pkg::DATA_W-1:0]   rsp_removed_value,
   output logic        [mhdm_pkg::STATUS_W-1:0] rsp_status,
   output logic        [mhdm_pkg::TOTAL_W-1:0]  rsp_element_total
);
   import mhdm_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int IW = AW + 2;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_RD_ROOT  = 3'd1;
   localparam logic [2:0] S_RD_LAST  = 3'd2;
   localparam logic [2:0] S_CHECK    = 3'd3;
   localparam logic [2:0] S_RD_LEFT  = 3'd4;
   localparam logic [2:0] S_RD_RIGHT = 3'd5;

   logic [2:0]          state_ff, state_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       idx_ff, idx_in;
   word_type            x_ff, x_in;
   word_type            best_ff, best_in;
   logic                take_ff, take_in;
   word_type            removed_ff, removed_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic                rsp_valid_ff, rsp_valid_in;

   logic                wr_en, rd_en;
   logic [AW-1:0]       wr_addr, rd_addr;
   word_type            wr_data, rd_data;

   logic [IW-1:0]       left_w, right_w, count_w;
   word_type            cmp_b;
   logic                gt;

   mhdm_ram #(
      .WIDTH(DATA_W),
      .DEPTH(CAPACITY)
   ) u_store (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign left_w  = IW'({idx_ff, 1'b1});
   assign right_w = left_w + IW'(1);
   assign count_w = IW'(count_ff);

   // shared comparator
   assign cmp_b = (state_ff == S_RD_RIGHT) ? best_ff : x_ff;
   assign gt    = rd_data > cmp_b;

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      idx_in       = idx_ff;
      x_in         = x_ff;
      best_in      = best_ff;
      take_in      = take_ff;
      removed_in   = removed_ff;
      status_in    = status_ff;
      rsp_valid_in = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = idx_ff;
      wr_data      = x_ff;
      rd_en        = 1'b0;
      rd_addr      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_opcode == OP_APPEND) begin
                  rsp_valid_in = 1'b1;
                  removed_in   = '0;
                  if (count_ff >= CW'(CAPACITY)) begin
                     status_in = ST_FULL;
                  end else begin
                     status_in = ST_DONE;
                     wr_en     = 1'b1;
                     wr_addr   = AW'(count_ff);
                     wr_data   = req_value;
                     count_in  = count_ff + CW'(1);
                  end
               end else if (count_ff == '0) begin
                  rsp_valid_in = 1'b1;
                  removed_in   = '0;
                  status_in    = ST_EMPTY;
               end else begin
                  rd_en    = 1'b1;
                  rd_addr  = '0;
                  state_in = S_RD_ROOT;
               end
            end
         end
         S_RD_ROOT: begin
            removed_in = rd_data;
            rd_en      = 1'b1;
            rd_addr    = AW'(count_ff - CW'(1));
            count_in   = count_ff - CW'(1);
            idx_in     = '0;
            state_in   = S_RD_LAST;
         end
         S_RD_LAST: begin
            x_in     = rd_data;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (left_w >= count_w) begin
               wr_en        = 1'b1;
               status_in    = ST_DONE;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = AW'(left_w);
               state_in = S_RD_LEFT;
            end
         end
         S_RD_LEFT: begin
            if (right_w < count_w) begin
               best_in  = gt ? rd_data : x_ff;
               take_in  = gt;
               rd_en    = 1'b1;
               rd_addr  = AW'(right_w);
               state_in = S_RD_RIGHT;
            end else if (gt) begin
               wr_en    = 1'b1;
               wr_data  = rd_data;
               idx_in   = AW'(left_w);
               state_in = S_CHECK;
            end else begin
               wr_en        = 1'b1;
               status_in    = ST_DONE;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_RD_RIGHT: begin
            if (gt) begin
               wr_en    = 1'b1;
               wr_data  = rd_data;
               idx_in   = AW'(right_w);
               state_in = S_CHECK;
            end else if (take_ff) begin
               wr_en    = 1'b1;
               wr_data  = best_ff;
               idx_in   = AW'(left_w);
               state_in = S_CHECK;
            end else begin
               wr_en        = 1'b1;
               status_in    = ST_DONE;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      x_ff       <= x_in;
      best_ff    <= best_in;
      take_ff    <= take_in;
      removed_ff <= removed_in;
      status_ff  <= status_in;
   end

   assign busy              = (state_ff != S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_removed_value = removed_ff;
   assign rsp_status        = status_ff;
   assign rsp_element_total = TOTAL_W'(count_ff);

   `MHDM_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(CAPACITY))
   `MHDM_ASSERT_NEXT(a_append_answers, clock, reset,
      start && !busy && req_opcode == OP_APPEND, rsp_valid && !busy)
   `MHDM_ASSERT_NOW(a_busy_from_delete, clock, reset, $rose(busy),
      $past(start && req_opcode == OP_DELETE && count_ff != '0))
   `MHDM_ASSERT_NOW(a_walk_ends_answered, clock, reset, $fell(busy),
      rsp_valid && status_ff == ST_DONE)
   `MHDM_ASSERT_NOW(a_empty_zero, clock, reset, rsp_valid && status_ff == ST_EMPTY,
      removed_ff == '0 && count_ff == '0)
endmodule
`default_nettype wire

// File: rtl/mhdm_ram.sv
// generic single write port, single read port ram with registered read
`default_nettype none
module mhdm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire
